/* hw/rtl/mcedr_pkg.sv */
// ----------------------------------------------------------------------------
// mcedr_pkg
// Shared constants, register codes and inter-module types of the multichannel
// moving-average deadband reporter.
// ----------------------------------------------------------------------------
package mcedr_pkg;

  localparam int unsigned MaxChannels   = 16;
  localparam int unsigned SampleBits    = 10;
  localparam int unsigned AlphaFracBits = 16;

  localparam int unsigned ChIdxW    = $clog2(MaxChannels);
  localparam int unsigned ChanW     = 4;
  localparam int unsigned LayerW    = 5;
  localparam int unsigned ActiveW   = 5;
  localparam int unsigned AlphaW    = 17;
  localparam int unsigned ThreshW   = 10;
  localparam int unsigned IdW       = 9;
  localparam int unsigned ValueW    = 10;
  localparam int unsigned SmoothW   = SampleBits + AlphaFracBits;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 17;

  localparam logic [AlphaW-1:0] AlphaOne   = AlphaW'(1) << AlphaFracBits;
  localparam logic [AlphaW-1:0] AlphaReset = AlphaW'(32768);
  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_ACTIVE    = 2'd1,
    CFG_ALPHA     = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                   wr;
    logic [ChIdxW-1:0]      ch;
    logic [SmoothW-1:0]     smoothed;
    logic                   wr_reported;
    logic [SampleBits-1:0]  reported;
  } st_wr_t;

  typedef struct packed {
    logic                   primed;
    logic [SmoothW-1:0]     smoothed;
    logic [SampleBits-1:0]  reported;
  } st_rd_t;

endpackage

/* hw/rtl/mcedr_chan_state.sv */
// ----------------------------------------------------------------------------
// mcedr_chan_state
// Per-channel smoothed value, last report and primed flag, one read and one
// write port addressed by channel.
// ----------------------------------------------------------------------------
module mcedr_chan_state (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mcedr_pkg::ChIdxW-1:0]        rd_ch_i,
  output mcedr_pkg::st_rd_t                   rd_o,
  input  mcedr_pkg::st_wr_t                   wr_i
);

  logic [mcedr_pkg::SmoothW-1:0]    smoothed_q [mcedr_pkg::MaxChannels];
  logic [mcedr_pkg::SampleBits-1:0] reported_q [mcedr_pkg::MaxChannels];
  logic [mcedr_pkg::MaxChannels-1:0] primed_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wr) begin
      smoothed_q[wr_i.ch] <= wr_i.smoothed;
      if (wr_i.wr_reported) begin
        reported_q[wr_i.ch] <= wr_i.reported;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= '0;
    end else if (wr_i.wr) begin
      primed_q[wr_i.ch] <= 1'b1;
    end
  end

  assign rd_o.primed   = primed_q[rd_ch_i];
  assign rd_o.smoothed = smoothed_q[rd_ch_i];
  assign rd_o.reported = reported_q[rd_ch_i];

endmodule

/* hw/rtl/mcedr_ema_calc.sv */
// ----------------------------------------------------------------------------
// mcedr_ema_calc
// Moving-average update, half-up rounding, deadband compare and report id
// for the item held in the input register.
// ----------------------------------------------------------------------------
module mcedr_ema_calc (
  input  logic                                go_i,
  input  logic                                enable_i,
  input  logic [mcedr_pkg::ActiveW-1:0]       active_i,
  input  logic [mcedr_pkg::AlphaW-1:0]        alpha_i,
  input  logic [mcedr_pkg::ThreshW-1:0]       thresh_i,
  input  logic [mcedr_pkg::ChanW-1:0]         channel_i,
  input  logic [mcedr_pkg::ValueW-1:0]        sample_i,
  input  logic [mcedr_pkg::LayerW-1:0]        layer_i,
  input  mcedr_pkg::st_rd_t                   st_i,
  output mcedr_pkg::st_wr_t                   wr_o,
  output logic                                report_o,
  output logic [mcedr_pkg::IdW-1:0]           id_o,
  output logic [mcedr_pkg::ValueW-1:0]        value_o
);

  localparam int unsigned DiffW = mcedr_pkg::SmoothW + 1;
  localparam int unsigned ProdW = DiffW + mcedr_pkg::AlphaW + 1;

  logic                                   active_ch;
  logic [mcedr_pkg::SampleBits-1:0]       smp;
  logic [mcedr_pkg::AlphaW-1:0]           a;
  logic [mcedr_pkg::SmoothW-1:0]          x;
  logic signed [DiffW-1:0]                diff;
  logic signed [ProdW-1:0]                prod;
  logic signed [ProdW-1:0]                step;
  logic [mcedr_pkg::SmoothW-1:0]          s_new;
  logic [mcedr_pkg::SmoothW-1:0]          s_rnd;
  logic [mcedr_pkg::SampleBits-1:0]       rounded;
  logic [mcedr_pkg::SampleBits-1:0]       delta;
  logic                                   over;
  logic [mcedr_pkg::IdW-1:0]              layer_m1;
  logic [mcedr_pkg::IdW-1:0]              stride;

  assign smp       = sample_i[mcedr_pkg::SampleBits-1:0];
  assign active_ch = ({1'b0, channel_i} < active_i) &&
                     ({1'b0, channel_i} < mcedr_pkg::ActiveW'(mcedr_pkg::MaxChannels));

  assign a    = (alpha_i > mcedr_pkg::AlphaOne) ? mcedr_pkg::AlphaOne : alpha_i;
  assign x    = {smp, {mcedr_pkg::AlphaFracBits{1'b0}}};
  assign diff = $signed({1'b0, x}) - $signed({1'b0, st_i.smoothed});
  assign prod = $signed({1'b0, a}) * diff;
  assign step = prod >>> mcedr_pkg::AlphaFracBits;

  assign s_new   = st_i.smoothed + step[mcedr_pkg::SmoothW-1:0];
  assign s_rnd   = s_new + (mcedr_pkg::SmoothW'(1) << (mcedr_pkg::AlphaFracBits - 1));
  assign rounded = s_rnd[mcedr_pkg::SmoothW-1:mcedr_pkg::AlphaFracBits];

  assign delta = (rounded >= st_i.reported) ? rounded - st_i.reported
                                            : st_i.reported - rounded;
  assign over  = mcedr_pkg::ThreshW'(delta) >= thresh_i;

  // id arithmetic wraps at the id width, layer zero included
  assign layer_m1 = mcedr_pkg::IdW'(layer_i) - mcedr_pkg::IdW'(1);
  assign stride   = layer_m1 * mcedr_pkg::IdW'(active_i);

  always_comb begin
    wr_o.wr          = go_i && enable_i && active_ch;
    wr_o.ch          = channel_i[mcedr_pkg::ChIdxW-1:0];
    wr_o.smoothed    = st_i.primed ? s_new : x;
    wr_o.wr_reported = !st_i.primed || over;
    wr_o.reported    = st_i.primed ? rounded : smp;
  end

  assign report_o = go_i && enable_i && active_ch && st_i.primed && over;
  assign id_o     = mcedr_pkg::IdW'(channel_i) + mcedr_pkg::IdW'(1) + stride;
  assign value_o  = mcedr_pkg::ValueW'(rounded);

endmodule

/* hw/rtl/multichannel_ema_deadband_reporter_unit.sv */
// ----------------------------------------------------------------------------
// multichannel_ema_deadband_reporter_unit
// Per-channel exponential moving average of converter samples with a
// deadband on the rounded value; reports changes with a layered channel id.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (channel, sample, layer) enter on in_valid_i/in_stall_o.
//   Reports (report_id, report_value) leave on out_valid_o/out_stall_i.
//   Configuration (enable, active count, alpha, threshold) is written through
//   cfg_we_i/cfg_idx_i/cfg_data_i while no request is in flight.
//   A request is captured in an input register; when the output register is
//   free it advances, the update, rounding and deadband compare run and any
//   report lands in the output register. One request per cycle is accepted
//   while the receiver does not stall; the combinational multiply-add into the
//   per-channel state sets that rate, and back-to-back requests on the same
//   channel see the state written by the previous one.
//   While the receiver stalls a held report, the input register fills and
//   then in_stall_o rises until the report is taken.
//   Reset clears the primed flags and resets the configuration; the first
//   request on a channel afterwards only primes it and gives no report.
// ----------------------------------------------------------------------------
module multichannel_ema_deadband_reporter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcedr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mcedr_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mcedr_pkg::ChanW-1:0]         channel_i,
  input  logic [mcedr_pkg::ValueW-1:0]        sample_i,
  input  logic [mcedr_pkg::LayerW-1:0]        layer_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mcedr_pkg::IdW-1:0]           report_id_o,
  output logic [mcedr_pkg::ValueW-1:0]        report_value_o
);

  logic                               enable_q;
  logic [mcedr_pkg::ActiveW-1:0]      active_q;
  logic [mcedr_pkg::AlphaW-1:0]       alpha_q;
  logic [mcedr_pkg::ThreshW-1:0]      thresh_q;

  logic                               in_vld_q;
  logic [mcedr_pkg::ChanW-1:0]        in_ch_q;
  logic [mcedr_pkg::ValueW-1:0]       in_smp_q;
  logic [mcedr_pkg::LayerW-1:0]       in_layer_q;

  logic                               out_vld_q;
  logic [mcedr_pkg::IdW-1:0]          out_id_q;
  logic [mcedr_pkg::ValueW-1:0]       out_val_q;

  logic                               out_free;
  logic                               adv;
  logic                               in_take;
  logic                               report;
  logic [mcedr_pkg::IdW-1:0]          rep_id;
  logic [mcedr_pkg::ValueW-1:0]       rep_val;
  mcedr_pkg::st_rd_t                  st_rd;
  mcedr_pkg::st_wr_t                  st_wr;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      active_q <= '0;
      alpha_q  <= mcedr_pkg::AlphaReset;
      thresh_q <= mcedr_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      unique case (mcedr_pkg::cfg_idx_e'(cfg_idx_i))
        mcedr_pkg::CFG_ENABLE:    enable_q <= cfg_data_i[0];
        mcedr_pkg::CFG_ACTIVE:    active_q <= cfg_data_i[mcedr_pkg::ActiveW-1:0];
        mcedr_pkg::CFG_ALPHA:     alpha_q  <= cfg_data_i[mcedr_pkg::AlphaW-1:0];
        mcedr_pkg::CFG_THRESHOLD: thresh_q <= cfg_data_i[mcedr_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_ch_q    <= channel_i;
      in_smp_q   <= sample_i;
      in_layer_q <= layer_i;
    end
  end

  mcedr_chan_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_ch_i (in_ch_q[mcedr_pkg::ChIdxW-1:0]),
    .rd_o    (st_rd),
    .wr_i    (st_wr)
  );

  mcedr_ema_calc u_calc (
    .go_i      (adv),
    .enable_i  (enable_q),
    .active_i  (active_q),
    .alpha_i   (alpha_q),
    .thresh_i  (thresh_q),
    .channel_i (in_ch_q),
    .sample_i  (in_smp_q),
    .layer_i   (in_layer_q),
    .st_i      (st_rd),
    .wr_o      (st_wr),
    .report_o  (report),
    .id_o      (rep_id),
    .value_o   (rep_val)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report) begin
      out_id_q  <= rep_id;
      out_val_q <= rep_val;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign report_id_o    = out_id_q;
  assign report_value_o = out_val_q;

  a_stall_needs_held_report: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && in_vld_q)
  ) else $error("input stalled without a held report");

  a_report_from_input_reg: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(adv)
  ) else $error("report appeared without an item leaving the input register");

  a_state_write_on_advance: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    st_wr.wr |-> (adv && enable_q)
  ) else $error("channel state written without an advancing item");

  a_report_needs_primed: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    report |-> (st_rd.primed && st_wr.wr && st_wr.wr_reported)
  ) else $error("report from an unprimed channel or without a state update");

endmodule

/* sim/mcedr_report_checker.sv */
// ----------------------------------------------------------------------------
// mcedr_report_checker
// Watches the configuration port and the request and report channels of the moving
// average deadband reporter. Mirrors the register file and the per-channel
// smoothing state, predicts each report when its request is taken, and
// compares every taken report field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mcedr_report_checker
  import mcedr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [ChanW-1:0]    channel_i,
  input  logic [ValueW-1:0]   sample_i,
  input  logic [LayerW-1:0]   layer_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [IdW-1:0]      report_id_i,
  input  logic [ValueW-1:0]   report_value_i,
  output int                  mismatches_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PrintCap = 40;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ValueW-1:0] value;
  } report_t;

  report_t expected_reports [$];

  logic [SmoothW-1:0] smoothed_level [MaxChannels];
  logic [ValueW-1:0]  last_reported  [MaxChannels];
  logic               primed         [MaxChannels];

  logic               cfg_enable;
  logic [ActiveW-1:0] cfg_active;
  logic [AlphaW-1:0]  cfg_alpha;
  logic [ThreshW-1:0] cfg_thresh;
  int                 mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PrintCap) begin
      $display("%0t ns: mismatch on %s, got %0d, want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic apply_config(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_ENABLE:    cfg_enable = data[0];
      CFG_ACTIVE:    cfg_active = data[ActiveW-1:0];
      CFG_ALPHA:     cfg_alpha  = data[AlphaW-1:0];
      CFG_THRESHOLD: cfg_thresh = data[ThreshW-1:0];
      default: ;
    endcase
  endtask

  // smoothing update, rounding and deadband decision for one request
  task automatic track_sample(input logic [ChanW-1:0] ch, input logic [ValueW-1:0] smp,
                              input logic [LayerW-1:0] lay);
    logic [63:0]        weight;
    logic [63:0]        acc;
    logic [SmoothW-1:0] next_level;
    logic [ValueW-1:0]  rounded;
    logic [ValueW-1:0]  last;
    logic [ValueW-1:0]  delta;
    logic [IdW-1:0]     id;
    report_t            rpt;
    if (!cfg_enable || ch >= cfg_active) return;
    if (!primed[ch]) begin
      primed[ch]         = 1'b1;
      smoothed_level[ch] = {smp, {AlphaFracBits{1'b0}}};
      last_reported[ch]  = smp;
      return;
    end
    weight = (cfg_alpha > AlphaOne) ? 64'(AlphaOne) : 64'(cfg_alpha);
    acc = weight * (64'(smp) << AlphaFracBits)
        + ((64'(1) << AlphaFracBits) - weight) * 64'(smoothed_level[ch]);
    next_level = SmoothW'(acc >> AlphaFracBits);
    smoothed_level[ch] = next_level;
    rounded = ValueW'((64'(next_level) + (64'(1) << (AlphaFracBits - 1))) >> AlphaFracBits);
    last  = last_reported[ch];
    delta = (rounded >= last) ? rounded - last : last - rounded;
    if (delta < cfg_thresh) return;
    last_reported[ch] = rounded;
    id = IdW'(ch) + IdW'(1) + (IdW'(lay) - IdW'(1)) * IdW'(cfg_active);
    rpt.id    = id;
    rpt.value = rounded;
    expected_reports.push_back(rpt);
  endtask

  task automatic check_report(input logic [IdW-1:0] id, input logic [ValueW-1:0] value);
    report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("report with nothing pending, id", int'(id), -1);
      return;
    end
    want = expected_reports.pop_front();
    if (id !== want.id) report_mismatch("report_id", int'(id), int'(want.id));
    if (value !== want.value) report_mismatch("report_value", int'(value), int'(want.value));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxChannels; i++) begin
        primed[i] = 1'b0;
      end
      cfg_enable = 1'b0;
      cfg_active = '0;
      cfg_alpha  = AlphaReset;
      cfg_thresh = ThreshReset;
      mismatches = 0;
      expected_reports.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_report(report_id_i, report_value_i);
      if (cfg_we_i) apply_config(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (in_valid_i && !in_stall_i) track_sample(channel_i, sample_i, layer_i);
    end
    pending_o    <= expected_reports.size();
    mismatches_o <= mismatches;
  end

endmodule

/* sim/multichannel_ema_deadband_reporter_unit_tb.sv */
// ----------------------------------------------------------------------------
// multichannel_ema_deadband_reporter_unit_tb
// Drives the moving average deadband reporter through a directed pass over
// the corner cases and then randomized phases under several register
// settings, with random gaps on the sender and random stalls on the receiver.
// A separate checker predicts and compares every report.
// ----------------------------------------------------------------------------
module multichannel_ema_deadband_reporter_unit_tb;
  import mcedr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SampleMax       = (1 << ValueW) - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ChanW-1:0]    channel_i;
  logic [ValueW-1:0]   sample_i;
  logic [LayerW-1:0]   layer_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [IdW-1:0]      report_id_o;
  logic [ValueW-1:0]   report_value_o;

  int mismatches;
  int reports_pending;
  int cycle_count   = 0;
  int hold_off_reqs = 0;
  int hold_off_ack  = 0;

  logic               enabled;
  logic [ActiveW-1:0] active_count;
  logic [ValueW-1:0]  last_sample [MaxChannels];

  multichannel_ema_deadband_reporter_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .layer_i        (layer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .report_id_o    (report_id_o),
    .report_value_o (report_value_o)
  );

  mcedr_report_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .layer_i        (layer_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .report_id_i    (report_id_o),
    .report_value_i (report_value_o),
    .mismatches_o   (mismatches),
    .pending_o      (reports_pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls, plus one long hold-off on request from the sender
  initial begin : receiver_stall
    int roll;
    int span;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_reqs != hold_off_ack) begin
        @(posedge clk_i);
        out_stall_i  <= 1'b1;
        hold_off_ack <= hold_off_reqs;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        roll = $urandom_range(0, 99);
        @(posedge clk_i);
        if (roll < 45) begin
          out_stall_i <= 1'b0;
          span = $urandom_range(1, 8);
        end else if (roll < 80) begin
          out_stall_i <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (roll < 92) begin
          out_stall_i <= 1'b0;
          span = $urandom_range(30, 80);
        end else begin
          out_stall_i <= 1'b1;
          span = $urandom_range(10, 40);
        end
        repeat (span - 1) @(posedge clk_i);
      end
    end
  end

  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic en, input logic [ActiveW-1:0] act,
                               input logic [AlphaW-1:0] weight,
                               input logic [ThreshW-1:0] thresh);
    write_register(CFG_ENABLE, CfgDataW'(en));
    write_register(CFG_ACTIVE, CfgDataW'(act));
    write_register(CFG_ALPHA, CfgDataW'(weight));
    write_register(CFG_THRESHOLD, CfgDataW'(thresh));
    cfg_we_i     <= 1'b0;
    enabled      = en;
    active_count = act;
  endtask

  task automatic offer_sample(input logic [ChanW-1:0] ch, input logic [ValueW-1:0] smp,
                              input logic [LayerW-1:0] lay);
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    layer_i    <= lay;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reports_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly active channels, samples either random, extreme or near the last one
  task automatic offer_random_items(input int how_many, input bit back_to_back);
    int               taken;
    int               roll;
    int               level;
    int               gap;
    int               span;
    logic [ChanW-1:0] ch;
    taken = 0;
    while (taken < how_many) begin
      span = (active_count > MaxChannels) ? MaxChannels : int'(active_count);
      if (span != 0 && $urandom_range(0, 99) < 88) ch = ChanW'($urandom_range(0, span - 1));
      else ch = ChanW'($urandom_range(0, MaxChannels - 1));
      roll = $urandom_range(0, 99);
      if (roll < 10) level = 0;
      else if (roll < 20) level = SampleMax;
      else if (roll < 55) level = $urandom_range(0, SampleMax);
      else begin
        level = int'(last_sample[ch]) + int'($urandom_range(0, 48)) - 24;
        if (level < 0) level = 0;
        if (level > SampleMax) level = SampleMax;
      end
      last_sample[ch] = ValueW'(level);
      offer_sample(ch, ValueW'(level), LayerW'($urandom_range(0, 31)));
      if (!enabled || ch < active_count) taken++;
      if (!back_to_back) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) gap = 0;
        else if (roll < 85) gap = $urandom_range(1, 3);
        else if (roll < 96) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_ENABLE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    channel_i  = '0;
    sample_i   = '0;
    layer_i    = LayerW'(1);
    enabled      = 1'b0;
    active_count = '0;
    for (int i = 0; i < MaxChannels; i++) begin
      last_sample[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // disabled: everything dropped
    load_settings(1'b0, ActiveW'(16), AlphaOne, ThreshW'(0));
    offer_sample(ChanW'(0), ValueW'(SampleMax), LayerW'(1));
    offer_sample(ChanW'(3), ValueW'(0), LayerW'(1));
    wait_drained();

    // full weight, zero threshold, extreme layers including zero
    load_settings(1'b1, ActiveW'(16), AlphaOne, ThreshW'(0));
    offer_sample(ChanW'(0), ValueW'(0), LayerW'(1));
    offer_sample(ChanW'(0), ValueW'(SampleMax), LayerW'(31));
    offer_sample(ChanW'(15), ValueW'(SampleMax), LayerW'(16));
    offer_sample(ChanW'(15), ValueW'(0), LayerW'(0));
    offer_sample(ChanW'(0), ValueW'(512), LayerW'(1));
    wait_drained();

    // weight above one, maximum threshold, inactive channels
    load_settings(1'b1, ActiveW'(3), AlphaW'('1), ThreshW'(SampleMax));
    offer_sample(ChanW'(5), ValueW'(100), LayerW'(1));
    offer_sample(ChanW'(3), ValueW'(100), LayerW'(1));
    offer_sample(ChanW'(2), ValueW'(0), LayerW'(2));
    offer_sample(ChanW'(2), ValueW'(SampleMax), LayerW'(2));
    offer_sample(ChanW'(2), ValueW'(SampleMax - 1), LayerW'(2));
    offer_sample(ChanW'(1), ValueW'(SampleMax), LayerW'(1));
    wait_drained();

    // zero weight, stride above sixteen
    load_settings(1'b1, ActiveW'(31), AlphaW'(0), ThreshW'(0));
    offer_sample(ChanW'(7), ValueW'(700), LayerW'(31));
    offer_sample(ChanW'(7), ValueW'(5), LayerW'(31));
    offer_sample(ChanW'(15), ValueW'(SampleMax), LayerW'(20));
    offer_sample(ChanW'(2), ValueW'(0), LayerW'(1));
    wait_drained();

    // half weight: rounding of an exact half goes up
    load_settings(1'b1, ActiveW'(16), AlphaReset, ThreshW'(1));
    offer_sample(ChanW'(4), ValueW'(0), LayerW'(1));
    offer_sample(ChanW'(4), ValueW'(1), LayerW'(1));
    wait_drained();

    // no active channels
    load_settings(1'b1, ActiveW'(0), AlphaW'(1), ThreshReset);
    offer_sample(ChanW'(0), ValueW'(5), LayerW'(1));

    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: load_settings(1'b1, ActiveW'(16), AlphaOne, ThreshW'(0));
        1: load_settings(1'b1, ActiveW'(1), AlphaReset, ThreshW'(1));
        2: load_settings(1'b1, ActiveW'(31), AlphaW'($urandom_range(0, AlphaOne)),
                         ThreshW'($urandom_range(0, 8)));
        3: load_settings(1'b1, ActiveW'($urandom_range(2, 16)), AlphaW'('1),
                         ThreshW'($urandom_range(2, 10)));
        4: load_settings(1'b1, ActiveW'($urandom_range(2, 16)), AlphaW'(1), ThreshW'(0));
        5: load_settings(1'b1, ActiveW'(16), AlphaOne, ThreshW'(SampleMax));
        6: load_settings(1'b0, ActiveW'(16), AlphaOne, ThreshW'(0));
        default: load_settings(1'b1, ActiveW'($urandom_range(2, 16)),
                               AlphaW'($urandom_range(0, AlphaOne)),
                               ThreshW'($urandom_range(0, 12)));
      endcase
      case (phase)
        0: begin
          offer_random_items(30, 1'b0);
          // receiver holds off while the sender keeps pushing
          in_valid_i    <= 1'b0;
          hold_off_reqs <= hold_off_reqs + 1;
          do @(posedge clk_i); while (hold_off_ack != hold_off_reqs);
          offer_random_items(40, 1'b1);
          offer_random_items(50, 1'b0);
        end
        2: begin
          offer_random_items(60, 1'b0);
          wait_drained();
          offer_random_items(60, 1'b0);
        end
        1, 4: begin
          offer_random_items(40, 1'b1);
          offer_random_items(80, 1'b0);
        end
        6: offer_random_items(20, 1'b0);
        default: offer_random_items(120, 1'b0);
      endcase
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mcedr_pkg.sv
hw/rtl/mcedr_chan_state.sv
hw/rtl/mcedr_ema_calc.sv
hw/rtl/multichannel_ema_deadband_reporter_unit.sv
sim/mcedr_report_checker.sv
sim/multichannel_ema_deadband_reporter_unit_tb.sv
